// File: rtl/core/path_component_splitter_macros.svh
// Assertion macros used by the path component splitter top level.
`ifndef PATH_COMPONENT_SPLITTER_MACROS_SVH
`define PATH_COMPONENT_SPLITTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pcs_pkg.sv
// Types and constants of the path component splitter.
`default_nettype none
package pcs_pkg;

  localparam int unsigned MaxNameLenDefault = 255;
  localparam int unsigned MaxDepthDefault   = 16;

  localparam logic [7:0] ChSep = 8'd47;
  localparam logic [7:0] ChDot = 8'd46;
  localparam logic [7:0] ChEnd = 8'd0;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_BYTE      = 3'd1,
    EV_COMP      = 3'd2,
    EV_PATH      = 3'd3,
    EV_COMP_PATH = 3'd4,
    EV_ERROR     = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_DEEP = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_DOTS     = 2'd3
  } err_e;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] name_byte;
    logic [7:0] position;
    logic [7:0] component_length;
    logic [4:0] components_seen;
    err_e       error_code;
  } result_t;

  typedef struct packed {
    logic       between;
    logic [4:0] depth;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/pcs_parser.sv
// Parse state and per-byte result logic of the path component splitter.
`default_nettype none
module pcs_parser #(
  parameter int unsigned MAX_NAME_LEN = pcs_pkg::MaxNameLenDefault,
  parameter int unsigned MAX_DEPTH    = pcs_pkg::MaxDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  output pcs_pkg::result_t       result_o,
  output pcs_pkg::status_t       status_o
);
  import pcs_pkg::*;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_NAME    = 2'd1,
    MODE_ERROR   = 2'd2
  } mode_e;

  localparam logic [7:0] NameLimit  = MAX_NAME_LEN[7:0];
  localparam logic [4:0] DepthLimit = MAX_DEPTH[4:0];

  mode_e      mode_q, mode_d;
  logic [7:0] count_q, count_d;
  logic [4:0] depth_q, depth_d;
  logic       dots_q, dots_d;

  logic       take;
  logic [7:0] base_count;
  logic       base_dots;
  logic       is_sep, is_end;
  logic [4:0] depth_inc;
  result_t    res;

  assign is_sep    = (byte_i == ChSep);
  assign is_end    = (byte_i == ChEnd);
  assign depth_inc = depth_q + 5'd1;

  always_comb begin
    res        = '0;
    mode_d     = mode_q;
    count_d    = count_q;
    depth_d    = depth_q;
    dots_d     = dots_q;
    take       = 1'b0;
    base_count = count_q;
    base_dots  = dots_q;

    case (mode_q)
      MODE_BETWEEN: begin
        if (is_sep) begin
          res.event_res = EV_NONE;
        end else if (is_end) begin
          res.event_res       = EV_PATH;
          res.components_seen = depth_q;
          mode_d  = MODE_BETWEEN;
          count_d = '0;
          depth_d = '0;
          dots_d  = 1'b1;
        end else if (depth_q >= DepthLimit) begin
          res.event_res  = EV_ERROR;
          res.error_code = ERR_TOO_DEEP;
          mode_d = MODE_ERROR;
        end else begin
          take       = 1'b1;
          base_count = '0;
          base_dots  = 1'b1;
        end
      end
      MODE_NAME: begin
        if (is_sep || is_end) begin
          if (dots_q && (count_q == 8'd1 || count_q == 8'd2)) begin
            res.event_res  = EV_ERROR;
            res.error_code = ERR_DOTS;
            if (is_end) begin
              mode_d  = MODE_BETWEEN;
              count_d = '0;
              depth_d = '0;
              dots_d  = 1'b1;
            end else begin
              mode_d = MODE_ERROR;
            end
          end else begin
            res.event_res        = is_end ? EV_COMP_PATH : EV_COMP;
            res.component_length = count_q;
            res.components_seen  = depth_inc;
            mode_d  = MODE_BETWEEN;
            count_d = '0;
            dots_d  = 1'b1;
            depth_d = is_end ? 5'd0 : depth_inc;
          end
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        // Error mode swallows bytes until the terminator restarts parsing.
        if (is_end) begin
          mode_d  = MODE_BETWEEN;
          count_d = '0;
          depth_d = '0;
          dots_d  = 1'b1;
        end
      end
    endcase

    if (take) begin
      count_d = base_count;
      dots_d  = base_dots;
      if (base_count >= NameLimit) begin
        res.event_res  = EV_ERROR;
        res.error_code = ERR_TOO_LONG;
        mode_d = MODE_ERROR;
      end else begin
        res.event_res = EV_BYTE;
        res.name_byte = byte_i;
        res.position  = base_count;
        count_d = base_count + 8'd1;
        dots_d  = base_dots & (byte_i == ChDot);
        mode_d  = MODE_NAME;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BETWEEN;
      count_q <= '0;
      depth_q <= '0;
      dots_q  <= 1'b1;
    end else if (step_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      depth_q <= depth_d;
      dots_q  <= dots_d;
    end
  end

  assign result_o         = res;
  assign status_o.between = (mode_q == MODE_BETWEEN);
  assign status_o.depth   = depth_q;

endmodule
`default_nettype wire

// File: rtl/core/pcs_out_stage.sv
// Result register of the path component splitter.
`default_nettype none
module pcs_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire pcs_pkg::result_t  result_i,
  input  wire logic              stall_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output pcs_pkg::result_t       result_o
);
  import pcs_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // The register can take a new result when empty or when its transfer completes now.
  assign ready_o = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule
`default_nettype wire

// File: rtl/core/path_component_splitter.sv
// An accepted byte is held in the input register; its result is then loaded into the result register.
// Throughput: one byte per cycle unless out_stall_i holds the result register full; the parse
// state updates in a single step between the input register and the result register.
// Exactly one result is produced per byte.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser
// to the between-components state with zero depth.
`default_nettype none
`include "path_component_splitter_macros.svh"
module path_component_splitter #(
  parameter int unsigned MAX_NAME_LEN = pcs_pkg::MaxNameLenDefault,
  parameter int unsigned MAX_DEPTH    = pcs_pkg::MaxDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  path_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       name_byte_o,
  output logic [7:0]       position_o,
  output logic [7:0]       component_length_o,
  output logic [4:0]       components_seen_o,
  output logic [1:0]       error_code_o
);
  import pcs_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_ready;
  logic       step;
  logic       in_take;
  result_t    step_res;
  result_t    out_res;
  status_t    status;

  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !out_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= path_byte_i;
    end
  end

  pcs_parser #(
    .MAX_NAME_LEN(MAX_NAME_LEN),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .result_o(step_res),
    .status_o(status)
  );

  pcs_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .result_i(step_res),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .result_o(out_res)
  );

  assign event_res_o        = out_res.event_res;
  assign name_byte_o        = out_res.name_byte;
  assign position_o         = out_res.position;
  assign component_length_o = out_res.component_length;
  assign components_seen_o  = out_res.components_seen;
  assign error_code_o       = out_res.error_code;

  `PCS_ASSERT_IMPL(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_o, "stall without a held byte and result")
  `PCS_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, step && (in_byte_q == ChEnd), status.between && (status.depth == 5'd0), "terminator did not clear the parse state")
  `PCS_ASSERT_IMPL(a_depth_bound, clk_i, rst_ni, 1'b1, {27'd0, status.depth} <= MAX_DEPTH, "depth beyond its limit")
  `PCS_ASSERT_IMPL(a_pos_bound, clk_i, rst_ni, out_valid_o && (out_res.event_res == EV_BYTE), {24'd0, out_res.position} < MAX_NAME_LEN, "name byte position beyond the name limit")

endmodule
`default_nettype wire

// File: verif/path_component_splitter_checker.sv
// Checker for the path component splitter: predicts every result and compares the outputs.
`timescale 1ns / 100ps
module path_component_splitter_checker
  import pcs_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN = MaxNameLenDefault,
  parameter int unsigned MAX_DEPTH    = MaxDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] path_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] event_res_i,
  input  logic [7:0] name_byte_i,
  input  logic [7:0] position_i,
  input  logic [7:0] component_length_i,
  input  logic [4:0] components_seen_i,
  input  logic [1:0] error_code_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         error_events_o,
  output int         live_bytes_o
);

  typedef enum logic [1:0] {
    MODE_GAP,
    MODE_NAME,
    MODE_SKIP
  } parse_mode_e;

  parse_mode_e mode;
  logic [7:0]  name_len;
  logic [4:0]  depth;
  logic        all_dots;

  result_t expected_results[$];
  result_t predicted;
  result_t want;
  int      mismatches;
  int      checked;
  int      error_events;
  int      live_bytes;

  task automatic clear_parser();
    mode     = MODE_GAP;
    name_len = '0;
    depth    = '0;
    all_dots = 1'b1;
  endtask

  task automatic take_name_byte(input logic [7:0] b, inout result_t r);
    if (name_len >= MAX_NAME_LEN) begin
      mode         = MODE_SKIP;
      r.event_res  = EV_ERROR;
      r.error_code = ERR_TOO_LONG;
    end else begin
      r.event_res = EV_BYTE;
      r.name_byte = b;
      r.position  = name_len;
      name_len    = name_len + 8'd1;
      if (b != ChDot) all_dots = 1'b0;
      mode = MODE_NAME;
    end
  endtask

  task automatic advance_parser(input logic [7:0] b, output result_t r);
    logic at_end;
    r = '0;
    at_end = (b == ChEnd);
    if (mode != MODE_SKIP) live_bytes++;
    case (mode)
      MODE_GAP: begin
        if (at_end) begin
          r.event_res       = EV_PATH;
          r.components_seen = depth;
          clear_parser();
        end else if (b != ChSep) begin
          if (depth >= MAX_DEPTH) begin
            mode         = MODE_SKIP;
            r.event_res  = EV_ERROR;
            r.error_code = ERR_TOO_DEEP;
          end else begin
            name_len = '0;
            all_dots = 1'b1;
            take_name_byte(b, r);
          end
        end
      end
      MODE_NAME: begin
        if (b == ChSep || at_end) begin
          if (all_dots && (name_len == 8'd1 || name_len == 8'd2)) begin
            r.event_res  = EV_ERROR;
            r.error_code = ERR_DOTS;
            if (at_end) clear_parser();
            else mode = MODE_SKIP;
          end else begin
            depth              = depth + 5'd1;
            r.event_res        = at_end ? EV_COMP_PATH : EV_COMP;
            r.component_length = name_len;
            r.components_seen  = depth;
            if (at_end) begin
              clear_parser();
            end else begin
              mode     = MODE_GAP;
              name_len = '0;
              all_dots = 1'b1;
            end
          end
        end else begin
          take_name_byte(b, r);
        end
      end
      default: begin
        // Everything up to the terminator is dropped after an error.
        if (at_end) clear_parser();
      end
    endcase
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned exp_val);
    if (mismatches < 40) begin
      $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
               $time, checked, field, got, exp_val);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
      mismatches     = 0;
      checked        = 0;
      error_events   = 0;
      live_bytes     = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
      error_events_o <= 0;
      live_bytes_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("transfer with nothing expected, event", event_res_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (event_res_i != want.event_res)
            report_mismatch("event", event_res_i, want.event_res);
          if (name_byte_i != want.name_byte)
            report_mismatch("name byte", name_byte_i, want.name_byte);
          if (position_i != want.position)
            report_mismatch("position", position_i, want.position);
          if (component_length_i != want.component_length)
            report_mismatch("component length", component_length_i, want.component_length);
          if (components_seen_i != want.components_seen)
            report_mismatch("components seen", components_seen_i, want.components_seen);
          if (error_code_i != want.error_code)
            report_mismatch("error code", error_code_i, want.error_code);
          if (want.event_res == EV_ERROR) error_events++;
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        advance_parser(path_byte_i, predicted);
        expected_results.push_back(predicted);
      end
      fail_count_o   <= mismatches;
      pending_o      <= expected_results.size();
      checked_o      <= checked;
      error_events_o <= error_events;
      live_bytes_o   <= live_bytes;
    end
  end

endmodule

// File: verif/tb.sv
// Testbench top for the path component splitter: clock, reset, paced path stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import pcs_pkg::*;

  localparam int unsigned NameLenMax    = MaxNameLenDefault;
  localparam int unsigned DepthMax      = MaxDepthDefault;
  localparam int          CycleLimit    = 100000;
  localparam int          BytesPerPhase = 120;

  // Empty path, collapsed slashes, "." at the terminator, ".." before a slash,
  // a legal "..." component and bytes with the top bits set.
  localparam logic [7:0] DirectedBytes [23] = '{
    ChEnd,
    ChSep, ChSep, 8'h61, ChSep, ChSep, ChEnd,
    ChDot, ChEnd,
    ChDot, ChDot, ChSep, 8'h78, ChEnd,
    ChDot, ChDot, ChDot, ChSep, ChEnd,
    8'hFF, 8'h80, ChSep, ChEnd
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] path_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_res;
  logic [7:0] name_byte;
  logic [7:0] position;
  logic [7:0] component_length;
  logic [4:0] components_seen;
  logic [1:0] error_code;

  int fail_count;
  int pending;
  int checked;
  int error_events;
  int live_bytes;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int paths_sent = 0;
  int phase_start;

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  path_component_splitter #(
    .MAX_NAME_LEN(NameLenMax),
    .MAX_DEPTH   (DepthMax)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .path_byte_i       (path_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .event_res_o       (event_res),
    .name_byte_o       (name_byte),
    .position_o        (position),
    .component_length_o(component_length),
    .components_seen_o (components_seen),
    .error_code_o      (error_code)
  );

  path_component_splitter_checker #(
    .MAX_NAME_LEN(NameLenMax),
    .MAX_DEPTH   (DepthMax)
  ) splitter_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .path_byte_i       (path_byte),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .event_res_i       (event_res),
    .name_byte_i       (name_byte),
    .position_i        (position),
    .component_length_i(component_length),
    .components_seen_i (components_seen),
    .error_code_i      (error_code),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .error_events_o    (error_events),
    .live_bytes_o      (live_bytes)
  );

  // Holds the byte until the transfer happens; optional idle cycles go first.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    path_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_name_byte(input bit plain);
    logic [7:0] b;
    if (!plain && $urandom_range(99) < 15) return ChDot;
    do b = 8'($urandom_range(255, 1)); while (b == ChSep);
    return b;
  endfunction

  task automatic send_component(input int len, input bit dots, input bit plain);
    for (int k = 0; k < len; k++) send_byte(dots ? ChDot : pick_name_byte(plain));
  endtask

  task automatic send_long_path(input int len);
    send_byte(ChSep);
    send_component(len, 1'b0, 1'b1);
    send_byte(ChSep);
    send_byte(ChEnd);
    paths_sent++;
  endtask

  // Mostly well-formed paths; a deep path runs up to and past the depth limit.
  task automatic send_random_path(input bit deep);
    int n_comps;
    int roll;
    roll = $urandom_range(99);
    if (!deep && roll < 10) begin
      // Noise: any nonzero bytes, slashes included.
      repeat ($urandom_range(20, 1)) send_byte(8'($urandom_range(255, 1)));
    end else begin
      repeat ($urandom_range(2)) send_byte(ChSep);
      n_comps = deep ? $urandom_range(DepthMax + 2, DepthMax) : $urandom_range(5);
      for (int c = 0; c < n_comps; c++) begin
        roll = $urandom_range(99);
        if (!deep && roll < 15) send_component($urandom_range(3, 1), 1'b1, 1'b0);
        else if (roll < 75) send_component($urandom_range(4, 1), 1'b0, deep);
        else send_component($urandom_range(12, 5), 1'b0, deep);
        if (c < n_comps - 1) repeat ($urandom_range(3, 1)) send_byte(ChSep);
        else if ($urandom_range(99) < 30) repeat ($urandom_range(2, 1)) send_byte(ChSep);
      end
    end
    send_byte(ChEnd);
    paths_sent++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);
    paths_sent += 6;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          stall_pct <= 58;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct <= 31;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
      endcase
      // The longest legal name, then one byte too many.
      if (phase == 0) send_long_path(NameLenMax);
      if (phase == 1) send_long_path(NameLenMax + 1);
      phase_start = live_bytes;
      send_random_path(1'b1);
      while (live_bytes - phase_start < BytesPerPhase) send_random_path(1'b0);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d paths with %0d parsed bytes under three pacing mixes,",
             paths_sent, live_bytes);
    $display("including full-length and overlong names; %0d results compared, %0d errors.",
             checked, error_events);
    if (fail_count == 0) begin
      $display("path_component_splitter verification clean");
    end else begin
      $display("path_component_splitter verification failed");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("path_component_splitter verification failed");
    $finish;
  end

endmodule
